// File: design/decimal_digit_formatter_core_macros.svh
`ifndef DECIMAL_DIGIT_FORMATTER_CORE_MACROS_SVH
`define DECIMAL_DIGIT_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DDF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ddf: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ddf: next-cycle check failed");

`endif

// File: design/ddf_pkg.sv
package ddf_pkg;

  localparam int MAX_DIGITS = 9;
  localparam int VALUE_W    = 30;
  localparam int BCD_DIGITS = 10;
  localparam int NUM_W      = 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_W + 1);
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_CONV,
    STEP_SETUP,
    STEP_EMIT
  } step_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CONV,
    OP_SETUP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_NO_ACCEPT,
    JC_BITS_LEFT,
    JC_NOT_DONE
  } jump_cond_t;

  typedef struct packed {
    op_t        op;
    jump_cond_t cond;
    step_t      target;
  } ctl_word_t;

  // Microprogram: one control word per step.
  function automatic ctl_word_t ucode(input step_t step);
    ctl_word_t w;
    case (step)
      STEP_IDLE:  w = '{op: OP_LOAD,  cond: JC_NO_ACCEPT, target: STEP_IDLE};
      STEP_CONV:  w = '{op: OP_CONV,  cond: JC_BITS_LEFT, target: STEP_CONV};
      STEP_SETUP: w = '{op: OP_SETUP, cond: JC_NONE,      target: STEP_IDLE};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: JC_NOT_DONE,  target: STEP_EMIT};
      default:    w = '{op: OP_LOAD,  cond: JC_NONE,      target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: design/decimal_digit_formatter_core.sv
// An accepted input word runs the serial binary-to-BCD loop over all 30 value
// bits, then a setup step, then 1 to 9 digit words go out, one per cycle while
// m_tready allows. Emitted digits stall in place while m_tready is low. A new
// input word is accepted only after its predecessor's last digit is registered.
// Synchronous active-high rst returns the sequencer to idle and drops m_tvalid.
`include "decimal_digit_formatter_core_macros.svh"

module decimal_digit_formatter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [29:0] value, [33:30] field_width, [34] zero_fill, [39:35] zero
  input  logic [ddf_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] digit, [7:4] column, [11:8] digit_count, [15:12] zero
  output logic [ddf_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import ddf_pkg::*;

  step_t                  step;
  step_t                  step_next;
  ctl_word_t              ctl;
  logic                   jump;
  logic                   out_free;

  logic [VALUE_W-1:0]     shreg;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [NUM_W-1:0]       bcd [BCD_DIGITS];
  logic [NUM_W-1:0]       adj [BCD_DIGITS];
  logic [NUM_W-1:0]       width;
  logic                   fill;

  logic [NUM_W-1:0]       cnt;
  logic                   sat;
  logic [NUM_W-1:0]       pos;
  logic [NUM_W-1:0]       col;

  logic [NUM_W-1:0]       cnt_raw;
  logic [NUM_W-1:0]       cap;
  logic                   sat_next;
  logic [NUM_W-1:0]       cnt_next;
  logic [NUM_W-1:0]       ndig;
  logic [NUM_W-1:0]       digit_sel;

  logic [VALUE_W-1:0]     in_value;
  logic [NUM_W-1:0]       in_width;
  logic                   in_fill;

  assign in_value = s_tdata[VALUE_W-1:0];
  assign in_width = s_tdata[VALUE_W +: NUM_W];
  assign in_fill  = s_tdata[VALUE_W + NUM_W];

  assign out_free = !m_tvalid || m_tready;

  // Control decode
  always_comb begin
    ctl      = ucode(step);
    s_tready = (ctl.op == OP_LOAD);
  end

  // Next step
  always_comb begin
    case (ctl.cond)
      JC_NONE:      jump = 1'b0;
      JC_NO_ACCEPT: jump = !s_tvalid;
      JC_BITS_LEFT: jump = (bit_cnt != BIT_CNT_W'(1));
      JC_NOT_DONE:  jump = !(out_free && pos == '0);
      default:      jump = 1'b0;
    endcase
    step_next = jump ? ctl.target : step_t'(step + 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Add-3 adjust ahead of each shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (bcd[k] >= NUM_W'(5)) ? bcd[k] + NUM_W'(3) : bcd[k];
    end
  end

  // Significant digits and saturation at the effective width
  always_comb begin
    cnt_raw = '0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd[k] != '0) cnt_raw = NUM_W'(k + 1);
    end
    cap      = (width == '0) ? NUM_W'(MAX_DIGITS) : width;
    sat_next = (cnt_raw > cap);
    cnt_next = sat_next ? cap : cnt_raw;
    if (width != '0 && fill) begin
      ndig = width;
    end else begin
      ndig = (cnt_next == '0) ? NUM_W'(1) : cnt_next;
    end
  end

  assign digit_sel = sat ? NUM_W'(9) : bcd[pos];

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (s_tvalid) begin
          shreg   <= in_value;
          bit_cnt <= BIT_CNT_W'(VALUE_W);
          width   <= (in_width > NUM_W'(MAX_DIGITS)) ? NUM_W'(MAX_DIGITS) : in_width;
          fill    <= in_fill;
          for (int k = 0; k < BCD_DIGITS; k++) bcd[k] <= '0;
        end
      end
      OP_CONV: begin
        shreg   <= {shreg[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt - BIT_CNT_W'(1);
        bcd[0]  <= {adj[0][NUM_W-2:0], shreg[VALUE_W-1]};
        for (int k = 1; k < BCD_DIGITS; k++) begin
          bcd[k] <= {adj[k][NUM_W-2:0], adj[k-1][NUM_W-1]};
        end
      end
      OP_SETUP: begin
        cnt <= cnt_next;
        sat <= sat_next;
        pos <= ndig - NUM_W'(1);
        col <= (width == '0) ? '0 : width - ndig;
      end
      OP_EMIT: begin
        if (out_free) begin
          pos <= pos - NUM_W'(1);
          col <= col + NUM_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.op == OP_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT && out_free) begin
      m_tdata <= {(OUT_DATA_W - 3 * NUM_W)'(0), cnt, col, digit_sel};
      m_tlast <= (pos == '0);
    end
  end

  `DDF_ASSERT_NEXT(a_accept_starts_conv, s_tvalid && s_tready, step == STEP_CONV)
  `DDF_ASSERT_NEXT(a_conv_ends, step == STEP_CONV && bit_cnt == BIT_CNT_W'(1),
                   step == STEP_SETUP)
  `DDF_ASSERT_NOW(a_digit_range, m_tvalid, m_tdata[NUM_W-1:0] <= NUM_W'(9))
  `DDF_ASSERT_NOW(a_column_range, m_tvalid,
                  m_tdata[2*NUM_W-1:NUM_W] < NUM_W'(MAX_DIGITS)
                  && m_tdata[3*NUM_W-1:2*NUM_W] <= NUM_W'(MAX_DIGITS))

endmodule
